@@ sv/lisr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the linear interpolation stereo resampler.
// Holds widths, register indexes, step limits and the request structs.
// No dependencies.
package lisr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;

  localparam int STEP_W    = 21;
  localparam int LIMIT_W   = 24;
  localparam int SRC_W     = 32;
  localparam int PHASE_W   = 48;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 24;
  localparam int MAX_RES   = 16;
  localparam int RUN_W     = $clog2(MAX_RES);

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;

  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(1 << (FRAC_BITS - 4));
  localparam logic [STEP_W-1:0] STEP_MAX   = STEP_W'(16 << FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(60211);

  localparam logic [CFG_IDX_W-1:0] REG_STEP      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = CFG_IDX_W'(1);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          first;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic        [LIMIT_W-1:0]     out_index;
    logic                          last_of_run;
  } out_req_t;

endpackage

@@ sv/linear_interp_stereo_resampler.sv @@
`timescale 1ns / 1ps
// Linear interpolation stereo resampler, top level; depends on lisr_pkg.
// A restart frame only loads the part state; any other frame goes through a check
// state, then for each output it causes (at most 16) through the states below,
// waiting in present while the output side stalls. A frame is taken only when idle;
// the one shared multiplier and rounding adder are each used for left then right.
// Reset (rst_ni low, async): idle, no part running, step = 60211, out_limit = 0.
module linear_interp_stereo_resampler (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // config write port
  input  logic                              cfg_we_i,
  input  logic [lisr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lisr_pkg::CFG_W-1:0]        cfg_wdata_i,
  // source frame requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lisr_pkg::in_req_t                 in_req_i,
  // interpolated frame requests
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lisr_pkg::out_req_t                out_req_o
);

  // One-hot sequencer. Per output: multiply left, round/add left,
  // multiply right, round/add right, present.
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_MUL_L = 7'b0000100,
    S_ADD_L = 7'b0001000,
    S_MUL_R = 7'b0010000,
    S_ADD_R = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [lisr_pkg::STEP_W-1:0]  step_q;
  logic [lisr_pkg::LIMIT_W-1:0] out_limit_q;

  // part state
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] prev_l_q, prev_r_q;
  logic                                    have_frame_q;
  logic [lisr_pkg::SRC_W-1:0]              src_index_q;
  logic [lisr_pkg::LIMIT_W-1:0]            out_count_q;
  logic [lisr_pkg::PHASE_W-1:0]            phase_q;

  // current frame work registers
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] new_l_q, new_r_q;
  logic signed [lisr_pkg::DIFF_W-1:0]      diff_l_q, diff_r_q;
  logic signed [lisr_pkg::PROD_W-1:0]      prod_q;
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] res_l_q;
  logic [lisr_pkg::RUN_W-1:0]              run_q;

  logic                                    out_valid_q;
  lisr_pkg::out_req_t                      out_req_q;

  // ---------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------
  logic in_acc, out_acc, restart;
  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign out_acc = out_valid_q && !out_stall_i;
  // a frame with no part running restarts the part like a first frame
  assign restart = in_req_i.first || !have_frame_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  // ---------------------------------------------------------------------
  // Step clamp, keeps one source frame to at most 16 outputs
  // ---------------------------------------------------------------------
  logic [lisr_pkg::STEP_W-1:0] step_sat;
  always_comb begin
    if (step_q < lisr_pkg::STEP_MIN) begin
      step_sat = lisr_pkg::STEP_MIN;
    end else if (step_q > lisr_pkg::STEP_MAX) begin
      step_sat = lisr_pkg::STEP_MAX;
    end else begin
      step_sat = step_q;
    end
  end

  // ---------------------------------------------------------------------
  // Emit condition: now (first output of a frame) and after this output
  // ---------------------------------------------------------------------
  logic [lisr_pkg::PHASE_W-1:0] phase_nx, ph_whole, ph_whole_nx;
  logic [lisr_pkg::LIMIT_W:0]   count_nx;
  logic                         emit_now, emit_next;

  assign phase_nx    = phase_q + lisr_pkg::PHASE_W'(step_sat);
  assign ph_whole    = phase_q >> lisr_pkg::FRAC_BITS;
  assign ph_whole_nx = phase_nx >> lisr_pkg::FRAC_BITS;
  assign count_nx    = {1'b0, out_count_q} + 1'b1;

  assign emit_now  = (out_count_q < out_limit_q) &&
                     (ph_whole[lisr_pkg::SRC_W-1:0] == src_index_q);
  assign emit_next = (run_q != {lisr_pkg::RUN_W{1'b1}}) &&
                     (count_nx < {1'b0, out_limit_q}) &&
                     (ph_whole_nx[lisr_pkg::SRC_W-1:0] == src_index_q);

  // ---------------------------------------------------------------------
  // Shared multiplier and round/add unit
  // ---------------------------------------------------------------------
  logic signed [lisr_pkg::DIFF_W-1:0]      mul_diff;
  logic signed [lisr_pkg::FRAC_BITS:0]     mul_frac;
  logic signed [lisr_pkg::PROD_W-1:0]      mul_prod;
  logic signed [lisr_pkg::PROD_W-1:0]      rnd_sum;
  logic signed [lisr_pkg::PROD_W-1:0]      rnd_shift;
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] add_prev;
  logic signed [lisr_pkg::DIFF_W-1:0]      add_sum;
  logic signed [lisr_pkg::SAMPLE_BITS-1:0] lerp_res;

  assign mul_diff = (state_q == S_MUL_L) ? diff_l_q : diff_r_q;
  assign mul_frac = $signed({1'b0, phase_q[lisr_pkg::FRAC_BITS-1:0]});
  assign mul_prod = lisr_pkg::PROD_W'(mul_diff * mul_frac);

  // round to nearest, ties up: floor((p + half) / 2^FRAC)
  assign rnd_sum   = prod_q + lisr_pkg::PROD_W'(1 << (lisr_pkg::FRAC_BITS - 1));
  assign rnd_shift = rnd_sum >>> lisr_pkg::FRAC_BITS;
  assign add_prev  = (state_q == S_ADD_L) ? prev_l_q : prev_r_q;
  assign add_sum   = lisr_pkg::DIFF_W'(add_prev) + rnd_shift[lisr_pkg::DIFF_W-1:0];
  // result lies between prev and new, so truncation is exact
  assign lerp_res  = add_sum[lisr_pkg::SAMPLE_BITS-1:0];

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && !restart) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: state_d = emit_now ? S_MUL_L : S_IDLE;
      S_MUL_L: state_d = S_ADD_L;
      S_ADD_L: state_d = S_MUL_R;
      S_MUL_R: state_d = S_ADD_R;
      S_ADD_R: state_d = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_d = out_req_q.last_of_run ? S_IDLE : S_MUL_L;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      step_q       <= lisr_pkg::STEP_RESET;
      out_limit_q  <= '0;
      prev_l_q     <= '0;
      prev_r_q     <= '0;
      have_frame_q <= 1'b0;
      src_index_q  <= '0;
      out_count_q  <= '0;
      phase_q      <= '0;
      run_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        if (cfg_idx_i == lisr_pkg::REG_STEP) begin
          step_q <= cfg_wdata_i[lisr_pkg::STEP_W-1:0];
        end else if (cfg_idx_i == lisr_pkg::REG_OUT_LIMIT) begin
          out_limit_q <= cfg_wdata_i[lisr_pkg::LIMIT_W-1:0];
        end
      end

      if (in_acc) begin
        run_q <= '0;
        if (restart) begin
          prev_l_q     <= in_req_i.left_in;
          prev_r_q     <= in_req_i.right_in;
          have_frame_q <= 1'b1;
          src_index_q  <= '0;
          out_count_q  <= '0;
          phase_q      <= '0;
        end
      end

      // frame done without output
      if (state_q == S_CHECK && !emit_now) begin
        prev_l_q    <= new_l_q;
        prev_r_q    <= new_r_q;
        src_index_q <= src_index_q + 1'b1;
      end

      if (state_q == S_ADD_R) begin
        out_valid_q <= 1'b1;
      end

      if (state_q == S_OUT && out_acc) begin
        out_valid_q <= 1'b0;
        out_count_q <= count_nx[lisr_pkg::LIMIT_W-1:0];
        phase_q     <= phase_nx;
        run_q       <= run_q + 1'b1;
        if (out_req_q.last_of_run) begin
          prev_l_q    <= new_l_q;
          prev_r_q    <= new_r_q;
          src_index_q <= src_index_q + 1'b1;
        end
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      new_l_q  <= in_req_i.left_in;
      new_r_q  <= in_req_i.right_in;
      diff_l_q <= lisr_pkg::DIFF_W'(in_req_i.left_in) - lisr_pkg::DIFF_W'(prev_l_q);
      diff_r_q <= lisr_pkg::DIFF_W'(in_req_i.right_in) - lisr_pkg::DIFF_W'(prev_r_q);
    end
    if (state_q == S_MUL_L || state_q == S_MUL_R) begin
      prod_q <= mul_prod;
    end
    if (state_q == S_ADD_L) begin
      res_l_q <= lerp_res;
    end
    if (state_q == S_ADD_R) begin
      out_req_q.left_out    <= res_l_q;
      out_req_q.right_out   <= lerp_res;
      out_req_q.out_index   <= out_count_q;
      out_req_q.last_of_run <= !emit_next;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a result is pending");

  a_out_needs_part: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> have_frame_q)
    else $error("result with no part running");

  a_last_frees_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_req_o.last_of_run) |=> !in_stall_o)
    else $error("block not ready after final result of a frame");

  a_more_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_req_o.last_of_run) |=> (state_q == S_MUL_L))
    else $error("run stopped before its final result");

endmodule
